// ----- hdl/sn2d_pkg.sv -----
// ----------------------------------------------------------------------------
// sn2d_pkg: shared types, constants and tables of the 2D simplex noise unit
// Fixed-point constants, the permutation table and the gradient decode.
// ----------------------------------------------------------------------------
package sn2d_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int COORD_W           = 32;
   localparam int NOISE_W           = 18;

   // skew and unskew factors in Q0.30
   localparam logic signed [29:0] F2_Q30   = 30'sd393016785;
   localparam logic [27:0]        G2_Q30   = 28'd226908346;
   localparam logic signed [31:0] G2_OFS   = 32'sd226908346;
   localparam logic signed [31:0] G2X2_OFS = 32'sd453816692;
   localparam logic signed [31:0] ONE_OFS  = 32'sd1073741824;
   localparam logic signed [34:0] HALF_Q30 = 35'sd536870912;

   localparam logic signed [NOISE_W-1:0] NOISE_MAX = 18'sd65536;
   localparam logic signed [NOISE_W-1:0] NOISE_MIN = -18'sd65536;

   localparam logic signed [1:0] SIGN_POS  = 2'sb01;
   localparam logic signed [1:0] SIGN_NEG  = 2'sb11;
   localparam logic signed [1:0] SIGN_ZERO = 2'sb00;

   typedef struct packed {
      logic signed [1:0] gx;
      logic signed [1:0] gy;
   } grad_type;

   localparam logic [7:0] PERM_TABLE [256] = '{
      8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
      8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
      8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
      8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
      8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
      8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
      8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
      8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
      8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
      8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
      8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
      8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
      8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
      8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
      8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
      8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
      8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
      8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
      8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
      8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
      8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
      8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
      8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
      8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
      8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
      8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
      8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
      8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
      8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
      8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
      8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
      8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
   };

   // hash mod 12: quotient by reciprocal 171/2048, exact for 8-bit values
   function automatic logic [3:0] mod12(input logic [7:0] h);
      logic [15:0] prod;
      logic [7:0]  quo;
      logic [7:0]  rem;
      prod = 16'(h) * 16'd171;
      quo  = 8'(prod[15:11]);
      rem  = h - 8'(quo * 8'd12);
      return rem[3:0];
   endfunction

   function automatic grad_type grad_of(input logic [3:0] idx);
      grad_type g;
      unique case (idx) inside
         4'd0:         g = '{gx: SIGN_POS,  gy: SIGN_POS};
         4'd1:         g = '{gx: SIGN_NEG,  gy: SIGN_POS};
         4'd2:         g = '{gx: SIGN_POS,  gy: SIGN_NEG};
         4'd3:         g = '{gx: SIGN_NEG,  gy: SIGN_NEG};
         4'd4, 4'd6:   g = '{gx: SIGN_POS,  gy: SIGN_ZERO};
         4'd5, 4'd7:   g = '{gx: SIGN_NEG,  gy: SIGN_ZERO};
         4'd8, 4'd10:  g = '{gx: SIGN_ZERO, gy: SIGN_POS};
         4'd9, 4'd11:  g = '{gx: SIGN_ZERO, gy: SIGN_NEG};
         default:      g = '{gx: SIGN_ZERO, gy: SIGN_ZERO};
      endcase
      return g;
   endfunction

endpackage

// ----- hdl/sn2d_req_if.sv -----
// ----------------------------------------------------------------------------
// sn2d_req_if: sample point channel
// Valid/ready channel carrying one Q15.16 coordinate pair per transaction.
// ----------------------------------------------------------------------------
interface sn2d_req_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sn2d_pkg::COORD_W-1:0]    x_coord;
   logic signed [sn2d_pkg::COORD_W-1:0]    y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

// ----- hdl/sn2d_rsp_if.sv -----
// ----------------------------------------------------------------------------
// sn2d_rsp_if: noise result channel
// Valid/ready channel carrying one Q1.16 noise value per transaction.
// ----------------------------------------------------------------------------
interface sn2d_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [sn2d_pkg::NOISE_W-1:0]    noise_value;

   modport source (output valid, output noise_value, input ready);
   modport sink   (input valid, input noise_value, output ready);
endinterface

// ----- hdl/simplex_noise_2d_unit.sv -----
// ----------------------------------------------------------------------------
// simplex_noise_2d_unit: pipelined 2D simplex noise
// Skew, cell lookup, three corner contributions, scale and saturate.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus takes one (x_coord, y_coord) pair per transaction, signed fixed
//   point with FRAC_BITS fraction bits. rsp_bus returns one noise_value per
//   point, signed Q1.16 saturated to [-1, 1], in the order points came in.
//   The pipeline has 12 register stages: a point's result shows on rsp_bus
//   once the point has passed through all of them. One point is taken every
//   cycle while the receiver does not hold a finished result back; the
//   twelve stages, with each multiplier (skew, unskew, squares,
//   t^2, t^4, gradient product) in a stage of its own, set the latency.
//   When the receiver holds rsp_bus.ready low while a result is shown, the
//   whole pipeline freezes and req_bus.ready drops in the same cycle; no
//   transaction is lost or repeated. Empty stages do not stall the input.
//   Synchronous reset empties the pipeline; tables are constants and need
//   no initialization.
// ----------------------------------------------------------------------------
module simplex_noise_2d_unit #(
   parameter int FRAC_BITS = sn2d_pkg::FRAC_BITS_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   sn2d_req_if.sink      req_bus,
   sn2d_rsp_if.source    rsp_bus
);

   localparam int SH   = FRAC_BITS + 30;
   localparam int NSTG = 12;

   logic             adv;
   logic [NSTG-1:0]  vld_ff;
   logic [NSTG-1:0]  vld_in;

   // stage 1: capture, x+y
   logic signed [31:0] x1_ff, y1_ff, x1_in, y1_in;
   logic signed [32:0] xy1_ff, xy1_in;
   // stage 2: skew product
   logic signed [31:0] x2_ff, y2_ff, x2_in, y2_in;
   logic signed [62:0] s2_ff, s2_in;
   // stage 3: skewed coordinates split into cell and fraction
   logic signed [63:0] xs3, ys3;
   logic [7:0]         ii3_ff, jj3_ff, ii3_in, jj3_in;
   logic [29:0]        fx3_ff, fy3_ff, fx3_in, fy3_in;
   // stage 4: unskew product, corner order, first hash level
   logic [30:0]        fsum4;
   logic [58:0]        tq_prod4;
   logic [7:0]         jj_p1;
   logic [29:0]        fx4_ff, fy4_ff, fx4_in, fy4_in;
   logic [28:0]        tq4_ff, tq4_in;
   logic               i14_ff, i14_in;
   logic [7:0]         ii4_ff, pj04_ff, pj14_ff, ii4_in, pj04_in, pj14_in;
   // stage 5: corner offsets and hash addresses
   logic signed [31:0] x05, y05;
   logic signed [31:0] dx5_ff [3];
   logic signed [31:0] dy5_ff [3];
   logic signed [31:0] dx5_in [3];
   logic signed [31:0] dy5_in [3];
   logic [7:0]         a5_ff [3];
   logic [7:0]         a5_in [3];
   // stage 6: second hash level and squares
   logic signed [63:0] sqx_prod [3];
   logic signed [63:0] sqy_prod [3];
   logic signed [31:0] dx6_ff [3];
   logic signed [31:0] dy6_ff [3];
   logic [32:0]        sqx6_ff [3];
   logic [32:0]        sqy6_ff [3];
   logic [32:0]        sqx6_in [3];
   logic [32:0]        sqy6_in [3];
   logic [7:0]         h6_ff [3];
   logic [7:0]         h6_in [3];
   // stage 7: falloff and gradient dot product
   logic signed [34:0] tfull7 [3];
   sn2d_pkg::grad_type grad7 [3];
   logic signed [33:0] termx7 [3];
   logic signed [33:0] termy7 [3];
   logic [29:0]        t7_ff [3];
   logic [29:0]        t7_in [3];
   logic signed [33:0] dot7_ff [3];
   logic signed [33:0] dot7_in [3];
   // stage 8: t^2
   logic [59:0]        t2_prod [3];
   logic [28:0]        t28_ff [3];
   logic [28:0]        t28_in [3];
   logic signed [33:0] dot8_ff [3];
   // stage 9: t^4
   logic [57:0]        t4_prod [3];
   logic [26:0]        t49_ff [3];
   logic [26:0]        t49_in [3];
   logic signed [33:0] dot9_ff [3];
   // stage 10: contribution
   logic signed [60:0] p10_ff [3];
   logic signed [60:0] p10_in [3];
   // stage 11: sum, floor to Q.40
   logic signed [62:0] sum11;
   logic signed [42:0] q11_ff, q11_in;
   // stage 12: scale by 70, round, saturate
   logic signed [49:0] rnd12;
   logic signed [25:0] r12;
   logic signed [sn2d_pkg::NOISE_W-1:0] noise_ff, noise_in;

   // advance everything unless a finished result is held by the receiver
   assign adv           = ~vld_ff[NSTG-1] | rsp_bus.ready;
   assign req_bus.ready = adv;
   assign vld_in        = {vld_ff[NSTG-2:0], req_bus.valid};

   assign rsp_bus.valid       = vld_ff[NSTG-1];
   assign rsp_bus.noise_value = noise_ff;

   always_comb begin
      x1_in  = req_bus.x_coord;
      y1_in  = req_bus.y_coord;
      xy1_in = 33'(req_bus.x_coord) + 33'(req_bus.y_coord);

      x2_in = x1_ff;
      y2_in = y1_ff;
      s2_in = 63'(xy1_ff) * 63'(sn2d_pkg::F2_Q30);

      xs3    = (64'(x2_ff) <<< 30) + 64'(s2_ff);
      ys3    = (64'(y2_ff) <<< 30) + 64'(s2_ff);
      ii3_in = xs3[SH+7:SH];
      jj3_in = ys3[SH+7:SH];
      fx3_in = xs3[SH-1:FRAC_BITS];
      fy3_in = ys3[SH-1:FRAC_BITS];

      fsum4    = {1'b0, fx3_ff} + {1'b0, fy3_ff};
      tq_prod4 = 59'(fsum4) * 59'(sn2d_pkg::G2_Q30);
      tq4_in   = tq_prod4[58:30];
      jj_p1    = jj3_ff + 8'd1;
      fx4_in   = fx3_ff;
      fy4_in   = fy3_ff;
      i14_in   = (fx3_ff > fy3_ff);
      ii4_in   = ii3_ff;
      pj04_in  = sn2d_pkg::PERM_TABLE[jj3_ff];
      pj14_in  = sn2d_pkg::PERM_TABLE[jj_p1];

      // equal fractions take the y step first
      x05       = $signed({2'b00, fx4_ff}) - $signed({3'b000, tq4_ff});
      y05       = $signed({2'b00, fy4_ff}) - $signed({3'b000, tq4_ff});
      dx5_in[0] = x05;
      dy5_in[0] = y05;
      dx5_in[1] = x05 - (i14_ff ? sn2d_pkg::ONE_OFS : 32'sd0) + sn2d_pkg::G2_OFS;
      dy5_in[1] = y05 - (i14_ff ? 32'sd0 : sn2d_pkg::ONE_OFS) + sn2d_pkg::G2_OFS;
      dx5_in[2] = x05 - sn2d_pkg::ONE_OFS + sn2d_pkg::G2X2_OFS;
      dy5_in[2] = y05 - sn2d_pkg::ONE_OFS + sn2d_pkg::G2X2_OFS;
      a5_in[0]  = ii4_ff + pj04_ff;
      a5_in[1]  = ii4_ff + {7'd0, i14_ff} + (i14_ff ? pj04_ff : pj14_ff);
      a5_in[2]  = ii4_ff + 8'd1 + pj14_ff;

      for (int k = 0; k < 3; k++) begin
         sqx_prod[k] = 64'(dx5_ff[k]) * 64'(dx5_ff[k]);
         sqy_prod[k] = 64'(dy5_ff[k]) * 64'(dy5_ff[k]);
         sqx6_in[k]  = sqx_prod[k][62:30];
         sqy6_in[k]  = sqy_prod[k][62:30];
         h6_in[k]    = sn2d_pkg::PERM_TABLE[a5_ff[k]];

         // negative falloff contributes nothing: clamp to zero
         tfull7[k] = sn2d_pkg::HALF_Q30 - $signed({2'b00, sqx6_ff[k]})
                     - $signed({2'b00, sqy6_ff[k]});
         t7_in[k]  = tfull7[k][34] ? 30'd0 : tfull7[k][29:0];
         grad7[k]  = sn2d_pkg::grad_of(sn2d_pkg::mod12(h6_ff[k]));
         case (grad7[k].gx)
            sn2d_pkg::SIGN_POS: termx7[k] = 34'(dx6_ff[k]);
            sn2d_pkg::SIGN_NEG: termx7[k] = -34'(dx6_ff[k]);
            default:            termx7[k] = 34'sd0;
         endcase
         case (grad7[k].gy)
            sn2d_pkg::SIGN_POS: termy7[k] = 34'(dy6_ff[k]);
            sn2d_pkg::SIGN_NEG: termy7[k] = -34'(dy6_ff[k]);
            default:            termy7[k] = 34'sd0;
         endcase
         dot7_in[k] = termx7[k] + termy7[k];

         t2_prod[k] = 60'(t7_ff[k]) * 60'(t7_ff[k]);
         t28_in[k]  = t2_prod[k][58:30];

         t4_prod[k] = 58'(t28_ff[k]) * 58'(t28_ff[k]);
         t49_in[k]  = t4_prod[k][56:30];

         p10_in[k]  = 61'($signed({1'b0, t49_ff[k]})) * 61'(dot9_ff[k]);
      end

      sum11  = 63'(p10_ff[0]) + 63'(p10_ff[1]) + 63'(p10_ff[2]);
      q11_in = sum11[62:20];

      // x70 as 64 + 4 + 2, then round half up at bit 23
      rnd12 = (50'(q11_ff) <<< 6) + (50'(q11_ff) <<< 2) + (50'(q11_ff) <<< 1)
              + 50'sd8388608;
      r12   = rnd12[49:24];
      if (r12 > 26'(sn2d_pkg::NOISE_MAX)) begin
         noise_in = sn2d_pkg::NOISE_MAX;
      end else if (r12 < 26'(sn2d_pkg::NOISE_MIN)) begin
         noise_in = sn2d_pkg::NOISE_MIN;
      end else begin
         noise_in = r12[sn2d_pkg::NOISE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff    <= x1_in;
         y1_ff    <= y1_in;
         xy1_ff   <= xy1_in;
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         s2_ff    <= s2_in;
         ii3_ff   <= ii3_in;
         jj3_ff   <= jj3_in;
         fx3_ff   <= fx3_in;
         fy3_ff   <= fy3_in;
         fx4_ff   <= fx4_in;
         fy4_ff   <= fy4_in;
         tq4_ff   <= tq4_in;
         i14_ff   <= i14_in;
         ii4_ff   <= ii4_in;
         pj04_ff  <= pj04_in;
         pj14_ff  <= pj14_in;
         for (int k = 0; k < 3; k++) begin
            dx5_ff[k]  <= dx5_in[k];
            dy5_ff[k]  <= dy5_in[k];
            a5_ff[k]   <= a5_in[k];
            dx6_ff[k]  <= dx5_ff[k];
            dy6_ff[k]  <= dy5_ff[k];
            sqx6_ff[k] <= sqx6_in[k];
            sqy6_ff[k] <= sqy6_in[k];
            h6_ff[k]   <= h6_in[k];
            t7_ff[k]   <= t7_in[k];
            dot7_ff[k] <= dot7_in[k];
            t28_ff[k]  <= t28_in[k];
            dot8_ff[k] <= dot7_ff[k];
            t49_ff[k]  <= t49_in[k];
            dot9_ff[k] <= dot8_ff[k];
            p10_ff[k]  <= p10_in[k];
         end
         q11_ff   <= q11_in;
         noise_ff <= noise_in;
      end
   end

endmodule

// ----- hdl/sn2d_checker.sv -----
// ----------------------------------------------------------------------------
// sn2d_checker: port-level checks of the simplex noise unit
// Watches the two channels of the top level; attached with bind.
// ----------------------------------------------------------------------------
module sn2d_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [sn2d_pkg::NOISE_W-1:0] noise_value
);

   // result always inside the saturation range
   a_noise_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (noise_value <= sn2d_pkg::NOISE_MAX &&
                     noise_value >= sn2d_pkg::NOISE_MIN))
      else $error("noise_value outside saturation range");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   // an empty output stage never back-pressures the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output stage empty");

   // a held result freezes the whole pipeline, input included
   a_stall_propagates: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("input accepted while output stalled");

   a_hold_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(noise_value)))
      else $error("stalled result changed");

endmodule

bind simplex_noise_2d_unit sn2d_checker u_sn2d_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .noise_value (rsp_bus.noise_value)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 2D simplex noise unit
// Sends sample points over the request channel and checks every noise value
// against a bit-exact fixed-point predictor, under random idling on both
// sides, one long result hold-off and one drain pause.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int     FRAC          = sn2d_pkg::FRAC_BITS_DEFAULT;
   localparam longint ONE_Q30       = 64'sd1073741824;
   localparam longint HALF_Q30_L    = 64'sd536870912;
   localparam longint SKEW_Q30      = 64'sd393016785;
   localparam longint UNSKEW_Q30    = 64'sd226908346;
   localparam longint UNSKEW2_Q30   = 64'sd453816692;
   localparam longint NOISE_CEIL    = 64'sd65536;
   localparam int     GRAD_X [12]   = '{1, -1, 1, -1, 1, -1, 1, -1, 0, 0, 0, 0};
   localparam int     GRAD_Y [12]   = '{1, 1, -1, -1, 0, 0, 0, 0, 1, -1, 1, -1};

   localparam int RANDOM_POINTS = 2000;
   localparam int IDLE_PCT      = 38;
   localparam int STEADY_FROM   = 1500;
   localparam int STEADY_TO     = 2100;
   localparam int HOLD_AT       = 800;
   localparam int HOLD_LEN      = 80;
   localparam int SPAN          = 20 * 65536;
   localparam int TAIL_CYCLES   = 24;
   localparam int STALL_LIMIT   = 3000;

   typedef struct {
      logic signed [sn2d_pkg::COORD_W-1:0] x;
      logic signed [sn2d_pkg::COORD_W-1:0] y;
      bit                                  drain_before;
   } point_type;

   logic clock;
   logic reset;

   sn2d_req_if req_bus ();
   sn2d_rsp_if rsp_bus ();

   simplex_noise_2d_unit u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   point_type                           point_queue [$];
   logic signed [sn2d_pkg::NOISE_W-1:0] noise_expect [$];
   point_type                           next_point;
   logic signed [sn2d_pkg::NOISE_W-1:0] want_noise;

   int error_cnt;
   int points_sent;
   int directed_cnt;
   int noise_checked;
   int saturated_cnt;
   int drain_pauses;
   int holds_done;
   int bench_cycle;
   int stall_cycles;
   int recv_cycle;
   int hold_left;

   // one corner's share in Q.60; offsets in Q.30
   function automatic longint corner_share(input longint dx, input longint dy, input int g);
      longint t;
      longint t2;
      longint t4;
      longint dot;
      t = HALF_Q30_L - ((dx * dx) >>> 30) - ((dy * dy) >>> 30);
      if (t < 0)
         return 0;
      t2  = (t * t) >>> 30;
      t4  = (t2 * t2) >>> 30;
      dot = GRAD_X[g] * dx + GRAD_Y[g] * dy;
      return t4 * dot;
   endfunction

   function automatic logic signed [sn2d_pkg::NOISE_W-1:0] simplex_at(
      input logic signed [sn2d_pkg::COORD_W-1:0] px,
      input logic signed [sn2d_pkg::COORD_W-1:0] py);
      longint      xl;
      longint      yl;
      longint      skew;
      logic [63:0] xs;
      logic [63:0] ys;
      logic [63:0] fmask;
      longint      fx;
      longint      fy;
      longint      tq;
      longint      x0, y0, x1, y1, x2, y2;
      longint      total;
      longint      q40;
      longint      r;
      int          ii, jj, step_i, step_j;
      int          g0, g1, g2;
      xl    = px;
      yl    = py;
      skew  = (xl + yl) * SKEW_Q30;
      xs    = xl * ONE_Q30 + skew;
      ys    = yl * ONE_Q30 + skew;
      fmask = (64'd1 << (FRAC + 30)) - 64'd1;
      ii    = int'((xs >> (FRAC + 30)) & 64'd255);
      jj    = int'((ys >> (FRAC + 30)) & 64'd255);
      fx    = longint'((xs & fmask) >> FRAC);
      fy    = longint'((ys & fmask) >> FRAC);
      tq    = ((fx + fy) * UNSKEW_Q30) >>> 30;
      x0    = fx - tq;
      y0    = fy - tq;
      // equal fractions take the upper triangle: y step first
      step_i = (fx > fy) ? 1 : 0;
      step_j = 1 - step_i;
      x1    = x0 - step_i * ONE_Q30 + UNSKEW_Q30;
      y1    = y0 - step_j * ONE_Q30 + UNSKEW_Q30;
      x2    = x0 - ONE_Q30 + UNSKEW2_Q30;
      y2    = y0 - ONE_Q30 + UNSKEW2_Q30;
      g0    = sn2d_pkg::PERM_TABLE[(ii + sn2d_pkg::PERM_TABLE[jj]) & 255] % 12;
      g1    = sn2d_pkg::PERM_TABLE[(ii + step_i +
                                    sn2d_pkg::PERM_TABLE[(jj + step_j) & 255]) & 255] % 12;
      g2    = sn2d_pkg::PERM_TABLE[(ii + 1 + sn2d_pkg::PERM_TABLE[(jj + 1) & 255]) & 255] % 12;
      total = corner_share(x0, y0, g0) + corner_share(x1, y1, g1) + corner_share(x2, y2, g2);
      q40   = total >>> 20;
      r     = (q40 * 70 + (64'sd1 <<< 23)) >>> 24;
      if (r > NOISE_CEIL)
         r = NOISE_CEIL;
      if (r < -NOISE_CEIL)
         r = -NOISE_CEIL;
      return r[sn2d_pkg::NOISE_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_cnt++;
   endtask

   task automatic queue_point(input logic signed [sn2d_pkg::COORD_W-1:0] px,
                              input logic signed [sn2d_pkg::COORD_W-1:0] py,
                              input bit drain);
      point_type p;
      p.x            = px;
      p.y            = py;
      p.drain_before = drain;
      point_queue.push_back(p);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            noise_expect.push_back(simplex_at(req_bus.x_coord, req_bus.y_coord));
            points_sent++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (point_queue.size() == 0 ||
                (point_queue[0].drain_before && noise_expect.size() != 0) ||
                (!(bench_cycle >= STEADY_FROM && bench_cycle < STEADY_TO) &&
                 $urandom_range(0, 99) < IDLE_PCT)) begin
               req_bus.valid <= 1'b0;
            end else begin
               next_point = point_queue.pop_front();
               if (next_point.drain_before)
                  drain_pauses++;
               req_bus.valid   <= 1'b1;
               req_bus.x_coord <= next_point.x;
               req_bus.y_coord <= next_point.y;
            end
         end
      end
   end

   // result receiver: random stalls plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_cycle = 0;
         hold_left  = 0;
      end else begin
         recv_cycle++;
         if (recv_cycle == HOLD_AT) begin
            hold_left = HOLD_LEN;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (bench_cycle >= STEADY_FROM && bench_cycle < STEADY_TO) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (noise_expect.size() == 0) begin
            report_mismatch($sformatf("noise_value %0d with no point outstanding",
                                      rsp_bus.noise_value));
         end else begin
            want_noise = noise_expect.pop_front();
            if (rsp_bus.noise_value !== want_noise)
               report_mismatch($sformatf("noise_value got %0d want %0d (result %0d)",
                                         rsp_bus.noise_value, want_noise, noise_checked));
            if (want_noise == sn2d_pkg::NOISE_MAX || want_noise == sn2d_pkg::NOISE_MIN)
               saturated_cnt++;
            noise_checked++;
         end
      end
   end

   // watchdog: cycles with no transaction on either channel
   always @(posedge clock) begin
      bench_cycle++;
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles == STALL_LIMIT) begin
            $display("Timeout after %0d idle cycles", STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      logic signed [sn2d_pkg::COORD_W-1:0] px;
      logic signed [sn2d_pkg::COORD_W-1:0] py;
      int                                  kind;
      int                                  n;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.x_coord = '0;
      req_bus.y_coord = '0;
      rsp_bus.ready   = 1'b0;
      error_cnt       = 0;
      points_sent     = 0;
      noise_checked   = 0;
      saturated_cnt   = 0;
      drain_pauses    = 0;
      holds_done      = 0;
      bench_cycle     = 0;
      stall_cycles    = 0;

      // directed: origin, field extremes, lattice points, cell edges, ties, wrap
      queue_point(32'sd0, 32'sd0, 1'b0);
      queue_point(32'sd1, 32'sd1, 1'b0);
      queue_point(-32'sd1, -32'sd1, 1'b0);
      queue_point(32'h7fffffff, 32'h7fffffff, 1'b0);
      queue_point(32'h80000000, 32'h80000000, 1'b0);
      queue_point(32'h7fffffff, 32'h80000000, 1'b0);
      queue_point(32'h80000000, 32'h7fffffff, 1'b0);
      queue_point(32'sd65536, 32'sd0, 1'b0);
      queue_point(32'sd0, 32'sd65536, 1'b0);
      queue_point(32'sd196608, 32'sd327680, 1'b0);
      queue_point(32'sd65535, 32'sd131071, 1'b0);
      queue_point(-32'sd65536, -32'sd131072, 1'b0);
      queue_point(32'sd32768, 32'sd32768, 1'b0);
      queue_point(-32'sd32768, -32'sd32768, 1'b0);
      queue_point(32'sd32768, -32'sd32768, 1'b0);
      queue_point(32'sd12345, 32'sd12345, 1'b0);
      queue_point(32'sd16777216, -32'sd16777216, 1'b0);
      queue_point(32'sd16842752, 32'sd65536, 1'b0);
      queue_point(32'h7fff0000, 32'sd0, 1'b0);
      queue_point(32'sd0, 32'h80010000, 1'b0);
      queue_point(32'h55555555, 32'haaaaaaaa, 1'b0);
      queue_point(32'haaaaaaaa, 32'h55555555, 1'b0);
      directed_cnt = point_queue.size();

      // random: full range, a dense region of small cells, diagonals, lattice
      for (n = 0; n < RANDOM_POINTS; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 4) begin
            px = $urandom;
            py = $urandom;
         end else if (kind < 8) begin
            px = int'($urandom_range(0, 2 * SPAN)) - SPAN;
            py = int'($urandom_range(0, 2 * SPAN)) - SPAN;
         end else if (kind == 8) begin
            px = int'($urandom_range(0, 2 * SPAN)) - SPAN;
            py = px + int'($urandom_range(0, 2)) - 1;
         end else begin
            px = (int'($urandom_range(0, 64)) - 32) * 65536;
            py = (int'($urandom_range(0, 64)) - 32) * 65536;
         end
         queue_point(px, py, n == RANDOM_POINTS / 2);
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (point_queue.size() != 0 || req_bus.valid)
         @(posedge clock);
      while (noise_expect.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d points (%0d directed), %0d noise values checked, %0d saturated",
               points_sent, directed_cnt, noise_checked, saturated_cnt);
      $display("Flow control: %0d long result hold-off(s), %0d drain pause(s), %0d cycles",
               holds_done, drain_pauses, bench_cycle);
      if (error_cnt == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("Mismatches: %0d", error_cnt);
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
